[hdl/gmhp_pkg.sv]
package gmhp_pkg;

    // One byte of the gzip file, with the end-of-file mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_word;

    // One parse result, produced on the final byte of a file.
    typedef struct packed {
        logic        header_ok;
        logic [31:0] body_offset;
        logic [31:0] uncompressed_size;
    } t_out_word;

    // Parser to output stage: a result word and whether one is produced.
    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_result;

endpackage

[hdl/gzip_member_header_parser.sv]
// Parses the header of a gzip member streamed in one byte per word, with the
// last byte of the file marked. The block accepts one byte every clock cycle
// while its input is not stalled; each byte is handled by a single pass
// through the parser logic between the parse state registers and the result
// register. Only the final byte produces a result word, which is written to
// the result register, or the skid one while output stalls. The output has a
// result register backed by one skid register, so input is stalled only when
// two finished results are both waiting for the consumer. The result reports
// whether the magic bytes, method, and length checks passed, the offset at
// which the deflate body starts, and ISIZE from the last four bytes; when the
// header is not valid both numeric fields are zero. The byte counter is
// COUNT_BITS wide and saturates; a file that runs past its limit is reported as
// invalid. After the final byte the parser returns to its reset state, ready
// for the next file.
module gzip_member_header_parser #(
    parameter int COUNT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gmhp_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gmhp_pkg::t_out_word o_out_word
);
    import gmhp_pkg::*;

    t_result   parse_res;
    logic      step;
    logic      pop;

    logic      r_out_valid;
    t_out_word r_out_word;
    logic      r_skid_valid;
    t_out_word r_skid_word;

    // Input is held off only while the skid register is occupied.
    assign o_in_ready  = !r_skid_valid;
    assign step        = i_in_valid && o_in_ready;
    assign pop         = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    gmhp_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (i_in_word),
        .o_result (parse_res)
    );

    // Output register with one skid entry. When the skid register holds a
    // word no new byte is accepted, so it only drains into the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= parse_res.valid;
        end else if (parse_res.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_word <= r_skid_word;
            end
        end else if (!r_out_valid || pop) begin
            if (parse_res.valid) begin
                r_out_word <= parse_res.word;
            end
        end else if (parse_res.valid) begin
            r_skid_word <= parse_res.word;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a word while the output register is empty");

    a_stalled_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (parse_res.valid && r_out_valid && !pop) |=> r_skid_valid)
        else $error("result produced behind a stalled output was dropped");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> (r_out_valid && !r_skid_valid))
        else $error("skid word did not move to the output register");

endmodule

[hdl/gmhp_parser.sv]
module gmhp_parser #(
    parameter int COUNT_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  gmhp_pkg::t_in_word i_word,
    output gmhp_pkg::t_result  o_result
);
    import gmhp_pkg::*;

    localparam int HeW       = COUNT_BITS + 1;
    localparam int HeSumW    = HeW + 1;
    localparam int ExtW      = HeW + 32;

    localparam logic [7:0] Id1Byte    = 8'h1f;
    localparam logic [7:0] Id2Byte    = 8'h8b;
    localparam logic [7:0] MethodByte = 8'h08;

    localparam int FlHcrc    = 1;
    localparam int FlExtra   = 2;
    localparam int FlName    = 3;
    localparam int FlComment = 4;

    typedef enum logic [10:0] {
        PH_ID1     = 11'b000_0000_0001,
        PH_ID2     = 11'b000_0000_0010,
        PH_CM      = 11'b000_0000_0100,
        PH_FLG     = 11'b000_0000_1000,
        PH_FIXED   = 11'b000_0001_0000,
        PH_XLO     = 11'b000_0010_0000,
        PH_XHI     = 11'b000_0100_0000,
        PH_XSKIP   = 11'b000_1000_0000,
        PH_NAME    = 11'b001_0000_0000,
        PH_COMMENT = 11'b010_0000_0000,
        PH_BODY    = 11'b100_0000_0000
    } t_phase;

    t_phase                r_phase,    n_phase;
    logic [COUNT_BITS-1:0] r_count,    n_count;
    logic                  r_ovf,      n_ovf;
    logic                  r_magic,    n_magic;
    logic [4:0]            r_flags,    n_flags;
    logic [16:0]           r_skip,     n_skip;
    logic [HeW-1:0]        r_hend,     n_hend;
    logic [31:0]           r_tail,     n_tail;

    logic                  sec_go;
    logic [1:0]            sec_stage;
    logic [16:0]           xlen;
    logic [2:0]            pend_add;
    logic [HeW-1:0]        off_full;
    logic [HeW-1:0]        len_m8;
    logic [ExtW-1:0]       off_ext;
    logic                  ok;

    // Saturating add for the header end offset.
    function automatic logic [HeW-1:0] he_add(logic [HeW-1:0] a, logic [17:0] b);
        logic [HeSumW-1:0] s;
        s = {1'b0, a} + HeSumW'(b);
        return s[HeW] ? {HeW{1'b1}} : s[HeW-1:0];
    endfunction

    // Next optional section once the given number of sections is behind us.
    function automatic t_phase section_after(logic [1:0] stage, logic [4:0] flags);
        if (stage < 2'd1 && flags[FlExtra]) begin
            return PH_XLO;
        end else if (stage < 2'd2 && flags[FlName]) begin
            return PH_NAME;
        end else if (stage < 2'd3 && flags[FlComment]) begin
            return PH_COMMENT;
        end
        return PH_BODY;
    endfunction

    always_comb begin
        n_phase   = r_phase;
        n_magic   = r_magic;
        n_flags   = r_flags;
        n_skip    = r_skip;
        n_hend    = r_hend;
        n_tail    = {i_word.data_byte, r_tail[31:8]};
        sec_go    = 1'b0;
        sec_stage = 2'd0;
        xlen      = {1'b0, i_word.data_byte, r_skip[7:0]};

        if (r_count == {COUNT_BITS{1'b1}}) begin
            n_count = r_count;
            n_ovf   = 1'b1;
        end else begin
            n_count = r_count + COUNT_BITS'(1);
            n_ovf   = r_ovf;
        end

        case (r_phase)
            PH_ID1: begin
                if (i_word.data_byte != Id1Byte) n_magic = 1'b0;
                n_phase = PH_ID2;
            end
            PH_ID2: begin
                if (i_word.data_byte != Id2Byte) n_magic = 1'b0;
                n_phase = PH_CM;
            end
            PH_CM: begin
                if (i_word.data_byte != MethodByte) n_magic = 1'b0;
                n_phase = PH_FLG;
            end
            PH_FLG: begin
                n_flags = i_word.data_byte[4:0];
                n_hend  = HeW'(10);
                n_phase = PH_FIXED;
            end
            PH_FIXED: begin
                // The fixed header ends with byte nine (XFL and OS behind MTIME).
                if (r_count >= COUNT_BITS'(9)) begin
                    sec_go    = 1'b1;
                    sec_stage = 2'd0;
                end
            end
            PH_XLO: begin
                n_skip  = {9'd0, i_word.data_byte};
                n_phase = PH_XHI;
            end
            PH_XHI: begin
                n_skip = xlen;
                n_hend = he_add(r_hend, 18'(xlen) + 18'd2);
                // The payload is only walked when a string field follows it.
                if (xlen != 17'd0 && (r_flags[FlName] || r_flags[FlComment])) begin
                    n_phase = PH_XSKIP;
                end else begin
                    sec_go    = 1'b1;
                    sec_stage = 2'd1;
                end
            end
            PH_XSKIP: begin
                n_skip = r_skip - 17'd1;
                if (n_skip == 17'd0) begin
                    sec_go    = 1'b1;
                    sec_stage = 2'd1;
                end
            end
            PH_NAME: begin
                n_hend = he_add(r_hend, 18'd1);
                if (i_word.data_byte == 8'd0) begin
                    sec_go    = 1'b1;
                    sec_stage = 2'd2;
                end
            end
            PH_COMMENT: begin
                n_hend = he_add(r_hend, 18'd1);
                if (i_word.data_byte == 8'd0) begin
                    sec_go    = 1'b1;
                    sec_stage = 2'd3;
                end
            end
            default: begin
                n_phase = PH_BODY;
            end
        endcase

        if (sec_go) begin
            n_phase = section_after(sec_stage, r_flags);
            if (n_phase == PH_BODY && r_flags[FlHcrc]) begin
                n_hend = he_add(n_hend, 18'd2);
            end
        end

        // Fields still open at end of file count their missing terminators and the header CRC.
        case (n_phase)
            PH_XSKIP, PH_NAME: begin
                pend_add = {2'b00, n_flags[FlName]} + {2'b00, n_flags[FlComment]}
                         + {1'b0, n_flags[FlHcrc], 1'b0};
            end
            PH_COMMENT: begin
                pend_add = 3'd1 + {1'b0, n_flags[FlHcrc], 1'b0};
            end
            default: begin
                pend_add = 3'd0;
            end
        endcase

        off_full = he_add(n_hend, 18'(pend_add));
        len_m8   = {1'b0, n_count} - HeW'(8);
        ok = !n_ovf && n_magic && (n_count >= COUNT_BITS'(18))
           && (n_phase inside {PH_XSKIP, PH_NAME, PH_COMMENT, PH_BODY})
           && (off_full < len_m8);
        off_ext = {32'd0, off_full};

        o_result.valid                  = i_step && i_word.final_byte;
        o_result.word.header_ok         = ok;
        o_result.word.body_offset       = ok ? off_ext[31:0] : 32'd0;
        o_result.word.uncompressed_size = ok ? n_tail : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.final_byte)) begin
            r_phase <= PH_ID1;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_magic <= 1'b1;
            r_flags <= '0;
            r_skip  <= '0;
            r_hend  <= '0;
            r_tail  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_magic <= n_magic;
            r_flags <= n_flags;
            r_skip  <= n_skip;
            r_hend  <= n_hend;
            r_tail  <= n_tail;
        end
    end

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == {COUNT_BITS{1'b1}}))
        else $error("overflow flag set while byte counter is not saturated");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.word.header_ok)
        |-> (o_result.word.body_offset == 32'd0 && o_result.word.uncompressed_size == 32'd0))
        else $error("invalid result carries nonzero fields");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_word.final_byte) |=> (r_phase == PH_ID1 && r_count == '0 && r_magic))
        else $error("parser did not restart after the final byte");

endmodule
